// ----- rtl/core/min_jerk_trajectory_point_defines.svh -----
// assertion macros shared by the minimum-jerk trajectory checker
`ifndef MIN_JERK_TRAJECTORY_POINT_DEFINES_SVH
`define MIN_JERK_TRAJECTORY_POINT_DEFINES_SVH

// property checked on every clock edge, ignored while reset is low
`define MJT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property checked on every clock edge, reset included
`define MJT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/core/mjt_pkg.sv -----
// shared constants, types and helpers of the minimum-jerk trajectory block
`default_nettype none
package mjt_pkg;

  localparam int unsigned VALUE_WIDTH_DEF = 32;
  localparam int unsigned SFRAC = 28;
  localparam int unsigned SW    = SFRAC + 1;
  localparam int unsigned P1W   = SFRAC + 2;
  localparam int unsigned P2W   = SFRAC + 3;
  localparam int unsigned PW    = SFRAC + 10;
  localparam int unsigned TW    = 32;
  localparam int unsigned DMW   = 32;
  localparam int unsigned VSH   = 12;
  localparam int unsigned QCLW  = 58;
  localparam int unsigned IDX_W = 3;

  localparam logic [IDX_W-1:0] REG_START_X  = 3'd0;
  localparam logic [IDX_W-1:0] REG_START_Y  = 3'd1;
  localparam logic [IDX_W-1:0] REG_START_Z  = 3'd2;
  localparam logic [IDX_W-1:0] REG_END_X    = 3'd3;
  localparam logic [IDX_W-1:0] REG_END_Y    = 3'd4;
  localparam logic [IDX_W-1:0] REG_END_Z    = 3'd5;
  localparam logic [IDX_W-1:0] REG_DURATION = 3'd6;

  localparam logic [TW-1:0]  DUR_RESET = 32'h0001_0000;
  localparam logic [DMW-1:0] DMAX      = 32'hFFFF_FFFF;

  localparam logic [7:0] C6   = 8'd6;
  localparam logic [7:0] C10  = 8'd10;
  localparam logic [7:0] C15  = 8'd15;
  localparam logic [7:0] C30  = 8'd30;
  localparam logic [7:0] C60  = 8'd60;
  localparam logic [7:0] C120 = 8'd120;
  localparam logic [7:0] C180 = 8'd180;

  localparam logic signed [PW-1:0] P_HI  = PW'(1) << SFRAC;
  localparam logic signed [PW-1:0] P1_HI = PW'(1) << (SFRAC + 1);
  localparam logic signed [PW-1:0] P2_HI = PW'(6) << SFRAC;

  typedef struct packed {
    logic [SW-1:0] s;
    logic [SW-1:0] s2;
    logic [SW-1:0] s3;
    logic [SW-1:0] s4;
    logic [SW-1:0] s5;
  } pow_t;

  function automatic logic [SW-1:0] mul_frac(input logic [SW-1:0] a, input logic [SW-1:0] b);
    logic [2*SW-1:0] m;
    m = a * b;
    return m[SFRAC+SW-1:SFRAC];
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/mjt_div.sv -----
// pipelined restoring divider, one quotient bit per stage, with overflow flag
`default_nettype none
module mjt_div #(
  parameter int unsigned NW = 60,
  parameter int unsigned DW = 32,
  parameter int unsigned QW = 29,
  parameter int unsigned SDW = 1
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  logic [NW-1:0]  num,
  input  logic [DW-1:0]  den,
  input  logic [SDW-1:0] side_in,
  output logic           out_valid,
  output logic [QW-1:0]  quo,
  output logic           out_sat,
  output logic [SDW-1:0] side_out
);

  localparam int unsigned HW = NW - QW;
  localparam int unsigned CW = (HW > DW) ? HW : DW;
  localparam int unsigned AW = DW + QW;

  logic [AW-1:0]  acc_r   [QW+1];
  logic [AW-1:0]  acc_nxt [QW+1];
  logic [AW:0]    shf     [QW];
  logic [DW+1:0]  dif     [QW];
  logic [SDW-1:0] side_r  [QW+1];
  logic [QW:0]    vld_r;
  logic [QW:0]    sat_r;
  logic [HW-1:0]  hi;
  logic           sat_nxt;

  always_comb begin
    hi         = num[NW-1:QW];
    sat_nxt    = (CW'(hi) >= CW'(den));
    acc_nxt[0] = {DW'(hi), num[QW-1:0]};
    for (int k = 1; k <= QW; k++) begin
      shf[k-1] = {acc_r[k-1], 1'b0};
      dif[k-1] = {1'b0, shf[k-1][AW:QW]} - {2'b00, den};
      if (!dif[k-1][DW+1]) begin
        acc_nxt[k] = {dif[k-1][DW-1:0], shf[k-1][QW-1:1], 1'b1};
      end else begin
        acc_nxt[k] = {shf[k-1][AW-1:QW], shf[k-1][QW-1:1], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[QW-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sat_r <= {sat_r[QW-1:0], sat_nxt};
      for (int k = 0; k <= QW; k++) begin
        acc_r[k] <= acc_nxt[k];
      end
      side_r[0] <= side_in;
      for (int k = 1; k <= QW; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  assign out_valid = vld_r[QW];
  assign quo       = acc_r[QW][QW-1:0];
  assign out_sat   = sat_r[QW];
  assign side_out  = side_r[QW];

endmodule
`default_nettype wire

// ----- rtl/core/min_jerk_trajectory_point.sv -----
// top level of the three-axis minimum-jerk trajectory point generator
//
//   channel | direction | handshake            | contents
//   in      | input     | in_valid / in_ready  | elapsed time, Q16.16 s
//   out     | output    | out_valid/out_ready  | position, velocity, acceleration
//   cfg     | input     | cfg_valid/cfg_ready  | register index and write data
//
// one transaction per cycle while the output register is empty or taken; a point passes
// through the time divider, the power chain and polynomials, the products,
// the jerk divider, the velocity/acceleration dividers and the output register
// all stages advance together whenever the output register is empty or taken
// synchronous active-low reset clears valid bits and start/end points and loads the reset duration
`default_nettype none
module min_jerk_trajectory_point #(
  parameter int unsigned VALUE_WIDTH = mjt_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic [mjt_pkg::TW-1:0]                   in_elapsed_time,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic signed [VALUE_WIDTH-1:0]            out_pos_x,
  output logic signed [VALUE_WIDTH-1:0]            out_pos_y,
  output logic signed [VALUE_WIDTH-1:0]            out_pos_z,
  output logic signed [VALUE_WIDTH-1:0]            out_vel_x,
  output logic signed [VALUE_WIDTH-1:0]            out_vel_y,
  output logic signed [VALUE_WIDTH-1:0]            out_vel_z,
  output logic signed [VALUE_WIDTH-1:0]            out_acc_x,
  output logic signed [VALUE_WIDTH-1:0]            out_acc_y,
  output logic signed [VALUE_WIDTH-1:0]            out_acc_z,
  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  logic [mjt_pkg::IDX_W-1:0]                cfg_index,
  input  logic [((VALUE_WIDTH > 32) ? VALUE_WIDTH : 32)-1:0] cfg_data
);

  localparam int unsigned W    = VALUE_WIDTH;
  localparam int unsigned MGW  = (W + 1 > 32) ? W + 1 : 33;
  localparam int unsigned SUMW = ((W > 34) ? W : 34) + 1;
  localparam int unsigned TNW  = mjt_pkg::TW + mjt_pkg::SFRAC;
  localparam int unsigned PPW  = mjt_pkg::DMW + mjt_pkg::SW;
  localparam int unsigned PVW  = mjt_pkg::DMW + mjt_pkg::P1W;
  localparam int unsigned PAW  = mjt_pkg::DMW + mjt_pkg::P2W;
  localparam int unsigned VNW  = PVW - mjt_pkg::VSH;
  localparam int unsigned Q1W  = mjt_pkg::QCLW + 1;
  localparam int unsigned A1SW = W + VNW + 2;
  localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

  logic en;

  logic signed [W-1:0]          start_r [3];
  logic signed [W-1:0]          end_r   [3];
  logic [mjt_pkg::TW-1:0]       dur_r;
  logic                         dneg_r  [3];
  logic [mjt_pkg::DMW-1:0]      dmag_r  [3];

  logic [mjt_pkg::TW-1:0]       tc;
  logic                         sq_valid;
  logic [mjt_pkg::SW-1:0]       s_q;

  mjt_pkg::pow_t                pw_r [4];
  logic [3:0]                   pw_v_r;

  logic signed [mjt_pkg::PW-1:0] pf, p1f, p2f;
  logic [mjt_pkg::SW-1:0]       p_nxt, p_r;
  logic [mjt_pkg::P1W-1:0]      p1_nxt, p1_r;
  logic [mjt_pkg::P2W-1:0]      p2m_nxt, p2m_r;
  logic                         p2n_nxt, p2n_r;
  logic                         v5_r, v6_r;

  logic [5:0]                   fin_v;
  logic                         out_valid_r;
  logic signed [W-1:0]          pos_o_r [3];
  logic signed [W-1:0]          vel_o_r [3];
  logic signed [W-1:0]          acc_o_r [3];

  assign en        = !out_valid_r || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        start_r[i] <= '0;
        end_r[i]   <= '0;
      end
      dur_r <= mjt_pkg::DUR_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        mjt_pkg::REG_START_X:  start_r[0] <= cfg_data[W-1:0];
        mjt_pkg::REG_START_Y:  start_r[1] <= cfg_data[W-1:0];
        mjt_pkg::REG_START_Z:  start_r[2] <= cfg_data[W-1:0];
        mjt_pkg::REG_END_X:    end_r[0]   <= cfg_data[W-1:0];
        mjt_pkg::REG_END_Y:    end_r[1]   <= cfg_data[W-1:0];
        mjt_pkg::REG_END_Z:    end_r[2]   <= cfg_data[W-1:0];
        mjt_pkg::REG_DURATION: begin
          dur_r <= (cfg_data[mjt_pkg::TW-1:0] == '0) ? mjt_pkg::TW'(1)
                                                      : cfg_data[mjt_pkg::TW-1:0];
        end
        default: ;
      endcase
    end
  end

  // normalised time s = tc / duration in Q.28
  assign tc = (in_elapsed_time > dur_r) ? dur_r : in_elapsed_time;

  mjt_div #(.NW(TNW), .DW(mjt_pkg::TW), .QW(mjt_pkg::SW), .SDW(1)) u_div_s (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .num      ({tc, {mjt_pkg::SFRAC{1'b0}}}),
    .den      (dur_r),
    .side_in  (1'b0),
    .out_valid(sq_valid),
    .quo      (s_q),
    .out_sat  (),
    .side_out ()
  );

  // power chain, one multiplier per stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pw_v_r <= '0;
    end else if (en) begin
      pw_v_r <= {pw_v_r[2:0], sq_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pw_r[0] <= {s_q, mjt_pkg::mul_frac(s_q, s_q), {(3*mjt_pkg::SW){1'b0}}};
      pw_r[1] <= {pw_r[0].s, pw_r[0].s2, mjt_pkg::mul_frac(pw_r[0].s2, pw_r[0].s),
                  {(2*mjt_pkg::SW){1'b0}}};
      pw_r[2] <= {pw_r[1].s, pw_r[1].s2, pw_r[1].s3,
                  mjt_pkg::mul_frac(pw_r[1].s3, pw_r[1].s), {mjt_pkg::SW{1'b0}}};
      pw_r[3] <= {pw_r[2].s, pw_r[2].s2, pw_r[2].s3, pw_r[2].s4,
                  mjt_pkg::mul_frac(pw_r[2].s4, pw_r[2].s)};
    end
  end

  // blend polynomial and its two derivatives
  always_comb begin
    pf  = $signed(mjt_pkg::PW'(pw_r[3].s3) * mjt_pkg::PW'(mjt_pkg::C10))
        - $signed(mjt_pkg::PW'(pw_r[3].s4) * mjt_pkg::PW'(mjt_pkg::C15))
        + $signed(mjt_pkg::PW'(pw_r[3].s5) * mjt_pkg::PW'(mjt_pkg::C6));
    p1f = $signed(mjt_pkg::PW'(pw_r[3].s2) * mjt_pkg::PW'(mjt_pkg::C30))
        - $signed(mjt_pkg::PW'(pw_r[3].s3) * mjt_pkg::PW'(mjt_pkg::C60))
        + $signed(mjt_pkg::PW'(pw_r[3].s4) * mjt_pkg::PW'(mjt_pkg::C30));
    p2f = $signed(mjt_pkg::PW'(pw_r[3].s) * mjt_pkg::PW'(mjt_pkg::C60))
        - $signed(mjt_pkg::PW'(pw_r[3].s2) * mjt_pkg::PW'(mjt_pkg::C180))
        + $signed(mjt_pkg::PW'(pw_r[3].s3) * mjt_pkg::PW'(mjt_pkg::C120));

    if (pf[mjt_pkg::PW-1]) begin
      p_nxt = '0;
    end else if (pf > mjt_pkg::P_HI) begin
      p_nxt = mjt_pkg::P_HI[mjt_pkg::SW-1:0];
    end else begin
      p_nxt = pf[mjt_pkg::SW-1:0];
    end

    if (p1f[mjt_pkg::PW-1]) begin
      p1_nxt = '0;
    end else if (p1f > mjt_pkg::P1_HI) begin
      p1_nxt = mjt_pkg::P1_HI[mjt_pkg::P1W-1:0];
    end else begin
      p1_nxt = p1f[mjt_pkg::P1W-1:0];
    end

    if (p2f > mjt_pkg::P2_HI) begin
      p2m_nxt = mjt_pkg::P2_HI[mjt_pkg::P2W-1:0];
      p2n_nxt = 1'b0;
    end else if (p2f < -mjt_pkg::P2_HI) begin
      p2m_nxt = mjt_pkg::P2_HI[mjt_pkg::P2W-1:0];
      p2n_nxt = 1'b1;
    end else if (p2f[mjt_pkg::PW-1]) begin
      p2m_nxt = mjt_pkg::P2W'(-p2f);
      p2n_nxt = 1'b1;
    end else begin
      p2m_nxt = p2f[mjt_pkg::P2W-1:0];
      p2n_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v5_r        <= pw_v_r[3];
      v6_r        <= v5_r;
      out_valid_r <= &fin_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r   <= p_nxt;
      p1_r  <= p1_nxt;
      p2m_r <= p2m_nxt;
      p2n_r <= p2n_nxt;
    end
  end

  // per-axis distance, products, division and saturation
  for (genvar a = 0; a < 3; a++) begin : g_axis
    logic signed [W:0]      diff;
    logic [W:0]             mag;
    logic [MGW-1:0]         mag_ext;
    logic [PPW-1:0]         prod_pos_r;
    logic [PVW-1:0]         prod_vel_r;
    logic [PAW-1:0]         prod_acc_r;
    logic                   aneg6_r;
    logic signed [SUMW-1:0] term, sum;
    logic signed [W-1:0]    pos_sat;
    logic                   a1_valid, a1_sat;
    logic [mjt_pkg::QCLW-1:0] a1_quo;
    logic [A1SW-1:0]        a1_side;
    logic [Q1W-1:0]         q1;
    logic [W-2:0]           vq, aq;
    logic                   vsat, asat;
    logic [W:0]             vside;
    logic                   aside;
    logic signed [W-1:0]    vel_nxt, acc_nxt;

    always_comb begin
      diff    = $signed({end_r[a][W-1], end_r[a]}) - $signed({start_r[a][W-1], start_r[a]});
      mag     = diff[W] ? (W+1)'(-diff) : diff;
      mag_ext = MGW'(mag);
    end

    always_ff @(posedge clk) begin
      dneg_r[a] <= diff[W];
      dmag_r[a] <= (mag_ext > MGW'(mjt_pkg::DMAX)) ? mjt_pkg::DMAX
                                                    : mag_ext[mjt_pkg::DMW-1:0];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        prod_pos_r <= PPW'(dmag_r[a]) * PPW'(p_r);
        prod_vel_r <= PVW'(dmag_r[a]) * PVW'(p1_r);
        prod_acc_r <= PAW'(dmag_r[a]) * PAW'(p2m_r);
        aneg6_r    <= dneg_r[a] ^ p2n_r;
      end
    end

    always_comb begin
      term = dneg_r[a] ? -SUMW'(prod_pos_r[PPW-1:mjt_pkg::SFRAC])
                       :  SUMW'(prod_pos_r[PPW-1:mjt_pkg::SFRAC]);
      sum  = SUMW'(start_r[a]) + term;
      if ((&sum[SUMW-1:W-1]) || !(|sum[SUMW-1:W-1])) begin
        pos_sat = sum[W-1:0];
      end else begin
        pos_sat = sum[SUMW-1] ? SMIN : SMAX;
      end
    end

    mjt_div #(.NW(PAW), .DW(mjt_pkg::TW), .QW(mjt_pkg::QCLW), .SDW(A1SW)) u_div_q (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_valid (v6_r),
      .num      (prod_acc_r),
      .den      (dur_r),
      .side_in  ({pos_sat, prod_vel_r[PVW-1:mjt_pkg::VSH], dneg_r[a], aneg6_r}),
      .out_valid(a1_valid),
      .quo      (a1_quo),
      .out_sat  (a1_sat),
      .side_out (a1_side)
    );

    assign q1 = a1_sat ? (Q1W'(1) << mjt_pkg::QCLW) : {1'b0, a1_quo};

    mjt_div #(.NW(VNW), .DW(mjt_pkg::TW), .QW(W-1), .SDW(W+1)) u_div_v (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_valid (a1_valid),
      .num      (a1_side[VNW+1:2]),
      .den      (dur_r),
      .side_in  ({a1_side[A1SW-1:VNW+2], a1_side[1]}),
      .out_valid(fin_v[2*a]),
      .quo      (vq),
      .out_sat  (vsat),
      .side_out (vside)
    );

    mjt_div #(.NW(Q1W+4), .DW(mjt_pkg::TW), .QW(W-1), .SDW(1)) u_div_a (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_valid (a1_valid),
      .num      ({q1, 4'b0000}),
      .den      (dur_r),
      .side_in  (a1_side[0]),
      .out_valid(fin_v[2*a+1]),
      .quo      (aq),
      .out_sat  (asat),
      .side_out (aside)
    );

    always_comb begin
      if (vsat) begin
        vel_nxt = vside[0] ? SMIN : SMAX;
      end else begin
        vel_nxt = vside[0] ? -$signed({1'b0, vq}) : $signed({1'b0, vq});
      end
      if (asat) begin
        acc_nxt = aside ? SMIN : SMAX;
      end else begin
        acc_nxt = aside ? -$signed({1'b0, aq}) : $signed({1'b0, aq});
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        pos_o_r[a] <= vside[W:1];
        vel_o_r[a] <= vel_nxt;
        acc_o_r[a] <= acc_nxt;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_pos_x = pos_o_r[0];
  assign out_pos_y = pos_o_r[1];
  assign out_pos_z = pos_o_r[2];
  assign out_vel_x = vel_o_r[0];
  assign out_vel_y = vel_o_r[1];
  assign out_vel_z = vel_o_r[2];
  assign out_acc_x = acc_o_r[0];
  assign out_acc_y = acc_o_r[1];
  assign out_acc_z = acc_o_r[2];

endmodule
`default_nettype wire

// ----- rtl/core/mjt_chk.sv -----
// port-level checker for the minimum-jerk trajectory block and its bind
`default_nettype none
`include "min_jerk_trajectory_point_defines.svh"
module mjt_chk #(
  parameter int unsigned VALUE_WIDTH = mjt_pkg::VALUE_WIDTH_DEF
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [VALUE_WIDTH-1:0] out_pos_x,
  input logic [VALUE_WIDTH-1:0] out_vel_x,
  input logic [VALUE_WIDTH-1:0] out_acc_x
);

  `MJT_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_pos_x) && $stable(out_vel_x) && $stable(out_acc_x), "result changed while stalled")
  `MJT_ASSERT(a_stall_blocks_in, out_valid && !out_ready |-> !in_ready, "input taken while output stalled")
  `MJT_ASSERT(a_ready_follows, out_ready |-> in_ready, "input not ready while output drains")
  `MJT_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind min_jerk_trajectory_point mjt_chk #(.VALUE_WIDTH(VALUE_WIDTH)) u_mjt_chk (.*);
`default_nettype wire

// ----- dv/min_jerk_trajectory_point_checker.sv -----
// checker that predicts and compares each trajectory point of the minimum-jerk block
module min_jerk_trajectory_point_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [31:0]        in_elapsed_time,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] out_pos_x,
  input  logic signed [31:0] out_pos_y,
  input  logic signed [31:0] out_pos_z,
  input  logic signed [31:0] out_vel_x,
  input  logic signed [31:0] out_vel_y,
  input  logic signed [31:0] out_vel_z,
  input  logic signed [31:0] out_acc_x,
  input  logic signed [31:0] out_acc_y,
  input  logic signed [31:0] out_acc_z,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output int                 fail_count,
  output int                 pending
);

  typedef logic [8:0][31:0] point_t;

  logic [31:0] start_pt [3];
  logic [31:0] end_pt [3];
  logic [31:0] duration;
  point_t      expected_points [$];
  int          point_num;

  function automatic logic [31:0] saturate(input longint v);
    if (v > 64'sd2147483647) return 32'h7fff_ffff;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic point_t trajectory_point(input logic [31:0] t_in);
    longint dur, t, s, s2, s3, s4, s5, p, p1, p2, st, en, d, q, dmax;
    point_t r;
    dur = longint'({32'd0, duration});
    if (dur == 0) dur = 1;
    t = longint'({32'd0, t_in});
    if (t > dur) t = dur;
    s  = (t << mjt_pkg::SFRAC) / dur;
    s2 = (s * s) >> mjt_pkg::SFRAC;
    s3 = (s2 * s) >> mjt_pkg::SFRAC;
    s4 = (s3 * s) >> mjt_pkg::SFRAC;
    s5 = (s4 * s) >> mjt_pkg::SFRAC;
    p  = clip(10 * s3 - 15 * s4 + 6 * s5, 0, 64'sd1 << mjt_pkg::SFRAC);
    p1 = clip(30 * s2 - 60 * s3 + 30 * s4, 0, 64'sd1 << (mjt_pkg::SFRAC + 1));
    p2 = clip(60 * s - 180 * s2 + 120 * s3, -6 * (64'sd1 << mjt_pkg::SFRAC),
              6 * (64'sd1 << mjt_pkg::SFRAC));
    dmax = 64'sh0000_0000_ffff_ffff;
    for (int a = 0; a < 3; a++) begin
      st = longint'($signed(start_pt[a]));
      en = longint'($signed(end_pt[a]));
      d  = clip(en - st, -dmax, dmax);
      q  = clip((d * p2) / dur, -(64'sd1 << 58), 64'sd1 << 58);
      r[a]     = saturate(st + (d * p) / (64'sd1 << mjt_pkg::SFRAC));
      r[3 + a] = saturate((d * p1) / (dur << mjt_pkg::VSH));
      r[6 + a] = saturate((q * 16) / dur);
    end
    return r;
  endfunction

  task automatic report_mismatch(input int field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch: point %0d field %0d got %h expected %h", point_num, field, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    point_t got, want;
    if (!rst_n) begin
      for (int a = 0; a < 3; a++) begin
        start_pt[a] = '0;
        end_pt[a] = '0;
      end
      duration = mjt_pkg::DUR_RESET;
      expected_points.delete();
      point_num = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          mjt_pkg::REG_START_X:  start_pt[0] = cfg_data;
          mjt_pkg::REG_START_Y:  start_pt[1] = cfg_data;
          mjt_pkg::REG_START_Z:  start_pt[2] = cfg_data;
          mjt_pkg::REG_END_X:    end_pt[0] = cfg_data;
          mjt_pkg::REG_END_Y:    end_pt[1] = cfg_data;
          mjt_pkg::REG_END_Z:    end_pt[2] = cfg_data;
          mjt_pkg::REG_DURATION: duration = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        got = {out_acc_z, out_acc_y, out_acc_x, out_vel_z, out_vel_y, out_vel_x,
               out_pos_z, out_pos_y, out_pos_x};
        if (expected_points.size() == 0) begin
          $display("unexpected transaction on the result channel");
          fail_count++;
        end else begin
          want = expected_points.pop_front();
          for (int f = 0; f < 9; f++)
            if (got[f] !== want[f]) report_mismatch(f, got[f], want[f]);
        end
        point_num++;
      end
      if (in_valid && in_ready) expected_points.push_back(trajectory_point(in_elapsed_time));
    end
    pending = expected_points.size();
  end
endmodule

// ----- dv/min_jerk_trajectory_point_test.sv -----
// testbench top: stimulus, traffic shaping and verdict for the minimum-jerk block
module min_jerk_trajectory_point_test;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 140;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [31:0]        in_elapsed_time;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] out_pos_x, out_pos_y, out_pos_z;
  logic signed [31:0] out_vel_x, out_vel_y, out_vel_z;
  logic signed [31:0] out_acc_x, out_acc_y, out_acc_z;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [2:0]         cfg_index;
  logic [31:0]        cfg_data;
  int                 fail_count;
  int                 pending;

  int          send_idle_pct;
  int          recv_idle_pct;
  logic        hold_request;
  int          hold_left;
  int          quiet_cycles;
  logic [31:0] cur_duration;

  min_jerk_trajectory_point dut (.*);

  min_jerk_trajectory_point_checker checker_i (.*);

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // receiver side, with an occasional long hold-off
  always @(negedge clk) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("** min_jerk_trajectory_point: FAILED **");
      $finish;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == mjt_pkg::REG_DURATION) cur_duration = value;
  endtask

  task automatic wait_idle();
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_move(input logic [31:0] sx, input logic [31:0] sy,
                           input logic [31:0] sz, input logic [31:0] ex,
                           input logic [31:0] ey, input logic [31:0] ez,
                           input logic [31:0] dur);
    in_valid <= 1'b0;
    wait_idle();
    write_reg(mjt_pkg::REG_START_X, sx);
    write_reg(mjt_pkg::REG_START_Y, sy);
    write_reg(mjt_pkg::REG_START_Z, sz);
    write_reg(mjt_pkg::REG_END_X, ex);
    write_reg(mjt_pkg::REG_END_Y, ey);
    write_reg(mjt_pkg::REG_END_Z, ez);
    write_reg(mjt_pkg::REG_DURATION, dur);
    // unused index, must be ignored
    write_reg(3'd7, $urandom);
  endtask

  task automatic send_time(input logic [31:0] t);
    in_valid <= 1'b1;
    in_elapsed_time <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(negedge clk);
    end
  endtask

  function automatic logic [31:0] rand_position();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom;
      default: return 32'($signed($urandom_range(20 << 16))) - 32'(10 << 16);
    endcase
  endfunction

  function automatic logic [31:0] rand_duration();
    case ($urandom_range(9))
      0: return 32'd0;
      1: return 32'hffff_ffff;
      2: return 32'd1;
      3: return $urandom;
      default: return $urandom_range(32'h0004_0000, 32'd2);
    endcase
  endfunction

  function automatic logic [31:0] rand_time(input logic [31:0] dur);
    case ($urandom_range(9))
      0: return 32'd0;
      1: return dur;
      2: return $urandom;
      3: return (dur > 32'hffff_fff0) ? dur : dur + $urandom_range(15, 1);
      default: return $urandom_range(dur, 0);
    endcase
  endfunction

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_elapsed_time = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    send_idle_pct = 13;
    recv_idle_pct = 48;
    hold_request = 1'b0;
    hold_left = 0;
    quiet_cycles = 0;
    cur_duration = mjt_pkg::DUR_RESET;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset configuration
    send_time(32'd0);
    send_time(32'h0000_8000);
    send_time(32'hffff_ffff);

    // ordinary move, start, middle, end and past the end
    load_move(32'hfffe_8000, 32'h0002_0000, 32'd0, 32'h0003_0000, 32'hffff_0000,
              32'h0000_4000, 32'h0002_0000);
    send_time(32'd0);
    send_time(32'd1);
    send_time(32'h0000_8000);
    send_time(32'h0001_0000);
    send_time(32'h0001_8000);
    send_time(32'h0002_0000);
    send_time(32'h0002_0001);
    send_time(32'hffff_ffff);

    // widest difference with the shortest duration
    load_move(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
              32'h8000_0000, 32'h8000_0000, 32'd1);
    send_time(32'd0);
    send_time(32'd1);
    send_time(32'hffff_ffff);

    // zero duration, then the longest one
    load_move(32'h8000_0000, 32'h7fff_ffff, 32'h0001_0000, 32'h7fff_ffff,
              32'h8000_0000, 32'hffff_0000, 32'd0);
    send_time(32'd0);
    send_time(32'd1);
    send_time(32'h5555_5555);
    load_move(32'h8000_0000, 32'h7fff_ffff, 32'h0001_0000, 32'h7fff_ffff,
              32'h8000_0000, 32'hffff_0000, 32'hffff_ffff);
    send_time(32'd0);
    send_time(32'haaaa_aaaa);
    send_time(32'h7fff_ffff);
    send_time(32'hffff_ffff);

    for (int phase = 0; phase < 9; phase++) begin
      if (phase == 3) begin
        send_idle_pct = 48;
        recv_idle_pct = 13;
      end else if (phase == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      load_move(rand_position(), rand_position(), rand_position(), rand_position(),
                rand_position(), rand_position(), rand_duration());
      for (int i = 0; i < 110; i++) begin
        if ((phase == 1 || phase == 7) && i == 20) hold_request = 1'b1;
        send_time(rand_time(cur_duration));
      end
    end

    in_valid <= 1'b0;
    wait_idle();
    if (fail_count == 0)
      $display("** min_jerk_trajectory_point: PASSED **");
    else
      $display("** min_jerk_trajectory_point: FAILED **");
    $finish;
  end
endmodule
